### hdl/ia64_integer_alu_execute_core_macros.svh
// assertion macros for the integer alu execute core
// expects clk_i and rst_ni in the scope of use
`ifndef IA64_INTEGER_ALU_EXECUTE_CORE_MACROS_SVH
`define IA64_INTEGER_ALU_EXECUTE_CORE_MACROS_SVH

// same-cycle implication
`define IA64_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IA64_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ia64alu_pkg.sv
// shared types, operation codes and helper functions for the integer alu
// no dependencies
`default_nettype none

package ia64alu_pkg;

  typedef enum logic [5:0] {
    OP_ADD      = 6'd0,
    OP_ADD1     = 6'd1,
    OP_ADDP4    = 6'd2,
    OP_AND      = 6'd3,
    OP_ANDCM    = 6'd4,
    OP_OR       = 6'd5,
    OP_XOR      = 6'd6,
    OP_SUB      = 6'd7,
    OP_SUB1     = 6'd8,
    OP_SHLADD   = 6'd9,
    OP_SHLADDP4 = 6'd10,
    OP_SHRP     = 6'd11,
    OP_DEP      = 6'd12,
    OP_DEPZ     = 6'd13,
    OP_EXTR     = 6'd14,
    OP_EXTRU    = 6'd15,
    OP_CZX1L    = 6'd16,
    OP_CZX1R    = 6'd17,
    OP_CZX2L    = 6'd18,
    OP_CZX2R    = 6'd19,
    OP_SXT1     = 6'd20,
    OP_SXT2     = 6'd21,
    OP_SXT4     = 6'd22,
    OP_ZXT1     = 6'd23,
    OP_ZXT2     = 6'd24,
    OP_ZXT4     = 6'd25,
    OP_CMP4_EQ  = 6'd26,
    OP_CMP4_NE  = 6'd27,
    OP_CMP4_GT  = 6'd28,
    OP_CMP4_GE  = 6'd29,
    OP_CMP4_LT  = 6'd30,
    OP_CMP4_LTU = 6'd31,
    OP_CMP4_LE  = 6'd32,
    OP_CMP_EQ   = 6'd33,
    OP_CMP_NE   = 6'd34,
    OP_CMP_GT   = 6'd35,
    OP_CMP_GE   = 6'd36,
    OP_CMP_LT   = 6'd37,
    OP_CMP_LTU  = 6'd38,
    OP_CMP_LE   = 6'd39,
    OP_TBIT_NZ  = 6'd40,
    OP_TBIT_Z   = 6'd41,
    OP_TNAT_NZ  = 6'd42,
    OP_TNAT_Z   = 6'd43
  } alu_op_e;

  localparam logic [6:0] FullLen = 7'd64;

  typedef struct packed {
    logic [63:0] add_x;
    logic [63:0] add_y;
    logic        add_cin;
    logic [63:0] shrp_res;
    logic [63:0] dep_mask;
    logic [63:0] a_shl_pos;
    logic [63:0] a_shr_pos;
    logic [63:0] ext_mask;
    logic        ext_sign;
    logic        tbit_bit;
  } prep_t;

  function automatic logic [63:0] low_ones(input logic [6:0] n);
    logic [63:0] m;
    if (n[6]) begin
      m = '1;
    end else begin
      m = ~({64{1'b1}} << n[5:0]);
    end
    return m;
  endfunction

  function automatic logic [3:0] czx1_left(input logic [63:0] a);
    logic [3:0] res;
    res = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (a[(7 - i) * 8 +: 8] == 8'd0) res = 4'(i);
    end
    return res;
  endfunction

  function automatic logic [3:0] czx1_right(input logic [63:0] a);
    logic [3:0] res;
    res = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (a[i * 8 +: 8] == 8'd0) res = 4'(i);
    end
    return res;
  endfunction

  function automatic logic [3:0] czx2_left(input logic [63:0] a);
    logic [3:0] res;
    res = 4'd4;
    for (int i = 3; i >= 0; i--) begin
      if (a[(3 - i) * 16 +: 16] == 16'd0) res = 4'(i);
    end
    return res;
  endfunction

  function automatic logic [3:0] czx2_right(input logic [63:0] a);
    logic [3:0] res;
    res = 4'd4;
    for (int i = 3; i >= 0; i--) begin
      if (a[i * 16 +: 16] == 16'd0) res = 4'(i);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/ia64alu_prep.sv
// operand preparation: shifters, field masks and adder inputs
// depends on ia64alu_pkg
`default_nettype none

module ia64alu_prep import ia64alu_pkg::*; (
  input  logic [5:0]  op_i,
  input  logic [63:0] src_a_i,
  input  logic [63:0] src_b_i,
  input  logic [5:0]  bit_pos_i,
  input  logic [6:0]  field_len_i,
  input  logic [5:0]  shift_count_i,
  output prep_t       prep_o
);

  alu_op_e      op;
  logic [6:0]   len_sat;
  logic [6:0]   end_pos;
  logic [6:0]   elen;
  logic [6:0]   sign_idx;
  logic [127:0] pair_shr;

  assign op       = alu_op_e'(op_i);
  assign len_sat  = (field_len_i > FullLen) ? FullLen : field_len_i;
  assign end_pos  = {1'b0, bit_pos_i} + len_sat;
  assign elen     = (end_pos > FullLen) ? (FullLen - {1'b0, bit_pos_i}) : len_sat;
  assign sign_idx = {1'b0, bit_pos_i} + elen - 7'd1;
  assign pair_shr = {src_a_i, src_b_i} >> shift_count_i;

  always_comb begin
    prep_o.add_x     = ((op == OP_SHLADD) || (op == OP_SHLADDP4)) ?
                       (src_a_i << shift_count_i) : src_a_i;
    prep_o.add_y     = ((op == OP_SUB) || (op == OP_SUB1)) ? ~src_b_i : src_b_i;
    prep_o.add_cin   = (op == OP_ADD1) || (op == OP_SUB);
    prep_o.shrp_res  = pair_shr[63:0];
    prep_o.dep_mask  = low_ones(len_sat) << bit_pos_i;
    prep_o.a_shl_pos = src_a_i << bit_pos_i;
    prep_o.a_shr_pos = src_a_i >> bit_pos_i;
    prep_o.ext_mask  = low_ones(elen);
    prep_o.ext_sign  = (elen != 7'd0) && (elen != FullLen) && src_a_i[sign_idx[5:0]];
    prep_o.tbit_bit  = src_a_i[bit_pos_i];
  end

endmodule

`default_nettype wire

### hdl/ia64_integer_alu_execute_core.sv
// done_o is registered: an accepted start passes through vld_q1 and vld_q2 before it sets done_q
// throughput: one transaction per cycle, busy is never raised
// stages: input register, operand preparation register, result register
// reset clears the valid flags of all stages; payload registers are not reset
// depends on ia64alu_pkg, ia64alu_prep and the assertion macro header
`default_nettype none
`include "ia64_integer_alu_execute_core_macros.svh"

module ia64_integer_alu_execute_core import ia64alu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  op_i,
  input  logic [63:0] src_a_i,
  input  logic [63:0] src_b_i,
  input  logic        nat_a_i,
  input  logic        nat_b_i,
  input  logic [5:0]  bit_pos_i,
  input  logic [6:0]  field_len_i,
  input  logic [5:0]  shift_count_i,
  input  logic        qual_pred_i,
  output logic        done_o,
  output logic [63:0] result_o,
  output logic        result_nat_o,
  output logic        pred_true_o,
  output logic        pred_false_o,
  output logic        is_pred_op_o
);

  // stage 1
  logic        vld_q1;
  logic [5:0]  op_q1;
  logic [63:0] a_q1, b_q1;
  logic        na_q1, nb_q1, qp_q1;
  logic [5:0]  pos_q1, cnt_q1;
  logic [6:0]  len_q1;

  // stage 2
  logic        vld_q2;
  logic [5:0]  op_q2;
  logic [63:0] a_q2, b_q2;
  logic        na_q2, nb_q2, qp_q2;
  prep_t       prep_d, prep_q2;

  // stage 3
  logic        done_q;
  logic [63:0] res_d, res_q;
  logic        rn_d, rn_q, p1_d, p1_q, p2_d, p2_q, isp_d, isp_q;

  alu_op_e     op2;
  logic [63:0] sum;
  logic [63:0] region;
  logic [63:0] ext_val;
  logic        eq32, lt32, ltu32, eq64, lt64, ltu64, rel;
  logic        both;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q1 <= 1'b0;
      vld_q2 <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q1 <= start && !busy;
      vld_q2 <= vld_q1;
      done_q <= vld_q2;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q1  <= op_i;
    a_q1   <= src_a_i;
    b_q1   <= src_b_i;
    na_q1  <= nat_a_i;
    nb_q1  <= nat_b_i;
    qp_q1  <= qual_pred_i;
    pos_q1 <= bit_pos_i;
    len_q1 <= field_len_i;
    cnt_q1 <= shift_count_i;
  end

  ia64alu_prep u_prep (
    .op_i          (op_q1),
    .src_a_i       (a_q1),
    .src_b_i       (b_q1),
    .bit_pos_i     (pos_q1),
    .field_len_i   (len_q1),
    .shift_count_i (cnt_q1),
    .prep_o        (prep_d)
  );

  always_ff @(posedge clk_i) begin
    op_q2   <= op_q1;
    a_q2    <= a_q1;
    b_q2    <= b_q1;
    na_q2   <= na_q1;
    nb_q2   <= nb_q1;
    qp_q2   <= qp_q1;
    prep_q2 <= prep_d;
  end

  assign op2     = alu_op_e'(op_q2);
  assign both    = na_q2 | nb_q2;
  assign sum     = prep_q2.add_x + prep_q2.add_y + {63'd0, prep_q2.add_cin};
  assign region  = {1'b0, b_q2[31:30], 29'd0, sum[31:0]};
  assign ext_val = (prep_q2.a_shr_pos & prep_q2.ext_mask) |
                   (prep_q2.ext_sign ? ~prep_q2.ext_mask : 64'd0);

  assign eq32  = a_q2[31:0] == b_q2[31:0];
  assign ltu32 = a_q2[31:0] < b_q2[31:0];
  assign lt32  = $signed(a_q2[31:0]) < $signed(b_q2[31:0]);
  assign eq64  = a_q2 == b_q2;
  assign ltu64 = a_q2 < b_q2;
  assign lt64  = $signed(a_q2) < $signed(b_q2);

  always_comb begin
    case (op2)
      OP_CMP4_EQ:  rel = eq32;
      OP_CMP4_NE:  rel = !eq32;
      OP_CMP4_GT:  rel = !lt32 && !eq32;
      OP_CMP4_GE:  rel = !lt32;
      OP_CMP4_LT:  rel = lt32;
      OP_CMP4_LTU: rel = ltu32;
      OP_CMP4_LE:  rel = lt32 || eq32;
      OP_CMP_EQ:   rel = eq64;
      OP_CMP_NE:   rel = !eq64;
      OP_CMP_GT:   rel = !lt64 && !eq64;
      OP_CMP_GE:   rel = !lt64;
      OP_CMP_LT:   rel = lt64;
      OP_CMP_LTU:  rel = ltu64;
      OP_CMP_LE:   rel = lt64 || eq64;
      OP_TBIT_NZ:  rel = prep_q2.tbit_bit;
      OP_TBIT_Z:   rel = !prep_q2.tbit_bit;
      OP_TNAT_NZ:  rel = na_q2;
      OP_TNAT_Z:   rel = !na_q2;
      default:     rel = 1'b0;
    endcase
  end

  always_comb begin
    res_d = 64'd0;
    rn_d  = 1'b0;
    p1_d  = 1'b0;
    p2_d  = 1'b0;
    isp_d = 1'b0;
    case (op2)
      OP_ADD, OP_ADD1, OP_SUB, OP_SUB1, OP_SHLADD: begin
        res_d = sum;
        rn_d  = both;
      end
      OP_ADDP4, OP_SHLADDP4: begin
        res_d = region;
        rn_d  = both;
      end
      OP_AND: begin
        res_d = a_q2 & b_q2;
        rn_d  = both;
      end
      OP_ANDCM: begin
        res_d = a_q2 & ~b_q2;
        rn_d  = both;
      end
      OP_OR: begin
        res_d = a_q2 | b_q2;
        rn_d  = both;
      end
      OP_XOR: begin
        res_d = a_q2 ^ b_q2;
        rn_d  = both;
      end
      OP_SHRP: begin
        res_d = prep_q2.shrp_res;
        rn_d  = both;
      end
      OP_DEP: begin
        res_d = (b_q2 & ~prep_q2.dep_mask) | (prep_q2.a_shl_pos & prep_q2.dep_mask);
        rn_d  = both;
      end
      OP_DEPZ: begin
        res_d = prep_q2.a_shl_pos & prep_q2.dep_mask;
        rn_d  = na_q2;
      end
      OP_EXTR: begin
        res_d = ext_val;
        rn_d  = na_q2;
      end
      OP_EXTRU: begin
        res_d = prep_q2.a_shr_pos & prep_q2.ext_mask;
        rn_d  = na_q2;
      end
      OP_CZX1L: begin
        res_d = {60'd0, czx1_left(a_q2)};
        rn_d  = na_q2;
      end
      OP_CZX1R: begin
        res_d = {60'd0, czx1_right(a_q2)};
        rn_d  = na_q2;
      end
      OP_CZX2L: begin
        res_d = {60'd0, czx2_left(a_q2)};
        rn_d  = na_q2;
      end
      OP_CZX2R: begin
        res_d = {60'd0, czx2_right(a_q2)};
        rn_d  = na_q2;
      end
      OP_SXT1: begin
        res_d = {{56{a_q2[7]}}, a_q2[7:0]};
        rn_d  = na_q2;
      end
      OP_SXT2: begin
        res_d = {{48{a_q2[15]}}, a_q2[15:0]};
        rn_d  = na_q2;
      end
      OP_SXT4: begin
        res_d = {{32{a_q2[31]}}, a_q2[31:0]};
        rn_d  = na_q2;
      end
      OP_ZXT1: begin
        res_d = {56'd0, a_q2[7:0]};
        rn_d  = na_q2;
      end
      OP_ZXT2: begin
        res_d = {48'd0, a_q2[15:0]};
        rn_d  = na_q2;
      end
      OP_ZXT4: begin
        res_d = {32'd0, a_q2[31:0]};
        rn_d  = na_q2;
      end
      OP_CMP4_EQ, OP_CMP4_NE, OP_CMP4_GT, OP_CMP4_GE, OP_CMP4_LT, OP_CMP4_LTU,
      OP_CMP4_LE, OP_CMP_EQ, OP_CMP_NE, OP_CMP_GT, OP_CMP_GE, OP_CMP_LT,
      OP_CMP_LTU, OP_CMP_LE: begin
        isp_d = 1'b1;
        if (qp_q2 && !both) begin
          p1_d = rel;
          p2_d = !rel;
        end
      end
      OP_TBIT_NZ, OP_TBIT_Z: begin
        isp_d = 1'b1;
        if (qp_q2 && !na_q2) begin
          p1_d = rel;
          p2_d = !rel;
        end
      end
      OP_TNAT_NZ, OP_TNAT_Z: begin
        isp_d = 1'b1;
        if (qp_q2) begin
          p1_d = rel;
          p2_d = !rel;
        end
      end
      default: begin
        res_d = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    rn_q  <= rn_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    isp_q <= isp_d;
  end

  assign done_o       = done_q;
  assign result_o     = res_q;
  assign result_nat_o = rn_q;
  assign pred_true_o  = p1_q;
  assign pred_false_o = p2_q;
  assign is_pred_op_o = isp_q;

  `IA64_ASSERT_NXT(a_strobe_follows, vld_q2, done_o, "stage 2 transaction lost")
  `IA64_ASSERT_NXT(a_no_spurious, !vld_q2, !done_o, "strobe without transaction")
  `IA64_ASSERT_IMP(a_pred_clean, done_o && is_pred_op_o, (result_o == 64'd0) && !result_nat_o, "predicate op with word result")
  `IA64_ASSERT_IMP(a_pred_excl, done_o, !(pred_true_o && pred_false_o), "both predicates set")

endmodule

`default_nettype wire
